// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/otb_pkg.sv -----
package otb_pkg;

   // Bank geometry
   localparam int NUM_TIMERS  = 16;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 16;
   localparam int SLOT_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   // Fixed transaction field widths
   localparam int OP_BITS        = 3;
   localparam int ID_BITS        = 4;
   localparam int TASK_BITS      = 8;
   localparam int PORT_TIME_BITS = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK    = 3'd0,
      OP_SET     = 3'd1,
      OP_RESET   = 3'd2,
      OP_DISABLE = 3'd3,
      OP_QUERY   = 3'd4
   } op_type;

   // Updates applied to the per-slot flag bits
   typedef enum logic [2:0] {
      FLAG_NONE,
      FLAG_SET,
      FLAG_REARM,
      FLAG_DISARM,
      FLAG_FIRE
   } flag_op_type;

   typedef struct packed {
      flag_op_type          op;
      logic [SLOT_BITS-1:0] slot;
   } flag_cmd_type;

   typedef struct packed {
      logic [NUM_TIMERS-1:0] registered;
      logic [NUM_TIMERS-1:0] armed;
      logic [NUM_TIMERS-1:0] pending;
   } flag_state_type;

   // One entry of the slot memory
   typedef struct packed {
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] deadline;
      logic [TASK_BITS-1:0] owner;
   } slot_entry_type;

endpackage

// ----- hw/rtl/otb_if.sv -----
// Request channel: one operation per transaction.
interface otb_req_if;
   logic                               valid;
   logic                               ready;
   logic [otb_pkg::OP_BITS-1:0]        op;
   logic [otb_pkg::ID_BITS-1:0]        timer_id;
   logic [otb_pkg::PORT_TIME_BITS-1:0] period_ms;
   logic [otb_pkg::TASK_BITS-1:0]      task_id;
   logic [otb_pkg::PORT_TIME_BITS-1:0] now_ms;

   modport source (output valid, op, timer_id, period_ms, task_id, now_ms, input ready);
   modport sink   (input valid, op, timer_id, period_ms, task_id, now_ms, output ready);
endinterface

// Response channel: one result per transaction.
interface otb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          fired_valid;
   logic [otb_pkg::ID_BITS-1:0]   fired_timer;
   logic [otb_pkg::TASK_BITS-1:0] fired_task;
   logic                          expired;
   logic                          last;

   modport source (output valid, fired_valid, fired_timer, fired_task, expired, last,
                   input ready);
   modport sink   (input valid, fired_valid, fired_timer, fired_task, expired, last,
                   output ready);
endinterface

// ----- hw/rtl/one_shot_timer_bank.sv -----
// Bank of 16 one-shot millisecond timers. Period, deadline and owner task of
// each slot sit in a single-port-read synchronous memory; the registered,
// armed and pending bits are flip-flops cleared by reset. Set, disable and
// query go straight to the final state; reset (re-arm) passes through a
// re-arm state first because it reads the stored period back from memory. A
// tick walks the slots in index order, one slot per cycle through the memory
// read port, except while a full output register holds back a fired result.
// Each fired slot gives one response transaction carrying its index and owner
// task; the final response of every request has last set. A new request is
// taken once the final response of the previous one is in the output
// register, even while that response is still waiting to be taken.
module one_shot_timer_bank (
   input logic        clock,
   input logic        reset,
   otb_req_if.sink    req_ch,
   otb_rsp_if.source  rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_REARM = 4'b0100,
      S_FINAL = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Slot memory
   otb_pkg::slot_entry_type slot_mem [otb_pkg::NUM_TIMERS];
   otb_pkg::slot_entry_type rd_data_ff;
   otb_pkg::slot_entry_type mem_wdata;
   logic [otb_pkg::SLOT_BITS-1:0] rd_addr;
   logic [otb_pkg::SLOT_BITS-1:0] mem_waddr;
   logic                          mem_we;

   // Flags
   otb_pkg::flag_cmd_type   flag_cmd;
   otb_pkg::flag_state_type flags;

   // Latched request
   logic [otb_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic [otb_pkg::TIME_BITS-1:0] now_ff, now_in;

   // Scan control
   logic [otb_pkg::SLOT_BITS-1:0] idx_ff, idx_in;
   logic [otb_pkg::CNT_BITS-1:0]  fire_cnt_ff, fire_cnt_in;

   // Result waiting for the output register
   logic                           held_valid_ff, held_valid_in;
   logic [otb_pkg::SLOT_BITS-1:0]  held_slot_ff, held_slot_in;
   logic [otb_pkg::TASK_BITS-1:0]  held_task_ff, held_task_in;
   logic                           expired_ff, expired_in;

   // Output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_fired_valid_ff, rsp_fired_valid_in;
   logic [otb_pkg::ID_BITS-1:0]    rsp_fired_timer_ff, rsp_fired_timer_in;
   logic [otb_pkg::TASK_BITS-1:0]  rsp_fired_task_ff, rsp_fired_task_in;
   logic                           rsp_expired_ff, rsp_expired_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           out_load;

   logic                           accept;
   logic                           out_free;
   otb_pkg::op_type                req_op;
   logic [otb_pkg::SLOT_BITS-1:0]  req_slot;
   logic                           req_in_range;
   logic [otb_pkg::TIME_BITS-1:0]  req_now;
   logic [otb_pkg::TIME_BITS-1:0]  req_period;
   logic                           due;
   logic                           stall;
   logic                           scan_go;
   logic                           scan_end;

   // Request decode
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_op       = otb_pkg::op_type'(req_ch.op);
   assign req_slot     = otb_pkg::SLOT_BITS'(req_ch.timer_id);
   assign req_in_range = int'(req_ch.timer_id) < otb_pkg::NUM_TIMERS;
   assign req_now      = req_ch.now_ms[otb_pkg::TIME_BITS-1:0];
   assign req_period   = req_ch.period_ms[otb_pkg::TIME_BITS-1:0];
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Scan of the slot whose entry is in rd_data_ff
   assign due = flags.registered[idx_ff] && flags.armed[idx_ff]
                && (rd_data_ff.deadline <= now_ff)
                && (fire_cnt_ff < otb_pkg::CNT_BITS'(otb_pkg::MAX_RESULTS));
   assign stall    = (state_ff == S_SCAN) && due && held_valid_ff && !out_free;
   assign scan_go  = (state_ff == S_SCAN) && !stall;
   assign scan_end = (idx_ff == otb_pkg::SLOT_BITS'(otb_pkg::NUM_TIMERS - 1));

   // Read address: a stalled scan re-reads its slot so the data holds
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_addr = (req_op == otb_pkg::OP_TICK) ? '0 : req_slot;
      end else if (stall) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = idx_ff + otb_pkg::SLOT_BITS'(1);
      end
   end

   // Memory write: set from the request, re-arm from the stored period
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_slot;
      mem_wdata.period   = req_period;
      mem_wdata.deadline = req_period + req_now;
      mem_wdata.owner    = req_ch.task_id;
      if (accept && req_in_range && (req_op == otb_pkg::OP_SET)) begin
         mem_we = 1'b1;
      end else if (state_ff == S_REARM) begin
         mem_we             = 1'b1;
         mem_waddr          = slot_ff;
         mem_wdata.period   = rd_data_ff.period;
         mem_wdata.deadline = rd_data_ff.period + now_ff;
         mem_wdata.owner    = rd_data_ff.owner;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   // Flag updates
   always_comb begin
      flag_cmd.op   = otb_pkg::FLAG_NONE;
      flag_cmd.slot = req_slot;
      if (accept && req_in_range && (req_op == otb_pkg::OP_SET)) begin
         flag_cmd.op = otb_pkg::FLAG_SET;
      end else if (accept && req_in_range && (req_op == otb_pkg::OP_DISABLE)) begin
         flag_cmd.op = otb_pkg::FLAG_DISARM;
      end else if (state_ff == S_REARM) begin
         flag_cmd.op   = otb_pkg::FLAG_REARM;
         flag_cmd.slot = slot_ff;
      end else if (scan_go && due) begin
         flag_cmd.op   = otb_pkg::FLAG_FIRE;
         flag_cmd.slot = idx_ff;
      end
   end

   otb_flag_bank u_flag_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (flag_cmd),
      .flags (flags)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      held_task_in  = held_task_ff;
      expired_in    = expired_ff;
      out_load      = 1'b0;
      rsp_fired_valid_in = 1'b0;
      rsp_fired_timer_in = '0;
      rsp_fired_task_in  = '0;
      rsp_expired_in     = 1'b0;
      rsp_last_in        = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               slot_in       = req_slot;
               now_in        = req_now;
               idx_in        = '0;
               fire_cnt_in   = '0;
               held_valid_in = 1'b0;
               expired_in    = (req_op == otb_pkg::OP_QUERY) && req_in_range
                               && flags.pending[req_slot];
               if (req_op == otb_pkg::OP_TICK) begin
                  state_in = S_SCAN;
               end else if ((req_op == otb_pkg::OP_RESET) && req_in_range) begin
                  state_in = S_REARM;
               end else begin
                  state_in = S_FINAL;
               end
            end
         end
         S_SCAN: begin
            if (scan_go) begin
               if (due) begin
                  // Earlier fired result is not the final one: send it now
                  if (held_valid_ff) begin
                     out_load           = 1'b1;
                     rsp_fired_valid_in = 1'b1;
                     rsp_fired_timer_in = otb_pkg::ID_BITS'(held_slot_ff);
                     rsp_fired_task_in  = held_task_ff;
                     rsp_last_in        = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_slot_in  = idx_ff;
                  held_task_in  = rd_data_ff.owner;
                  fire_cnt_in   = fire_cnt_ff + otb_pkg::CNT_BITS'(1);
               end
               idx_in = idx_ff + otb_pkg::SLOT_BITS'(1);
               if (scan_end) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_REARM: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               out_load           = 1'b1;
               rsp_fired_valid_in = held_valid_ff;
               rsp_fired_timer_in = held_valid_ff ? otb_pkg::ID_BITS'(held_slot_ff) : '0;
               rsp_fired_task_in  = held_valid_ff ? held_task_ff : '0;
               rsp_expired_in     = expired_ff;
               rsp_last_in        = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         fire_cnt_ff   <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         fire_cnt_ff   <= fire_cnt_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      now_ff       <= now_in;
      held_slot_ff <= held_slot_in;
      held_task_ff <= held_task_in;
      expired_ff   <= expired_in;
      if (out_load) begin
         rsp_fired_valid_ff <= rsp_fired_valid_in;
         rsp_fired_timer_ff <= rsp_fired_timer_in;
         rsp_fired_task_ff  <= rsp_fired_task_in;
         rsp_expired_ff     <= rsp_expired_in;
         rsp_last_ff        <= rsp_last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.fired_valid = rsp_fired_valid_ff;
   assign rsp_ch.fired_timer = rsp_fired_timer_ff;
   assign rsp_ch.fired_task  = rsp_fired_task_ff;
   assign rsp_ch.expired     = rsp_expired_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

// ----- hw/rtl/otb_flag_bank.sv -----
module otb_flag_bank (
   input  logic                    clock,
   input  logic                    reset,
   input  otb_pkg::flag_cmd_type   cmd,
   output otb_pkg::flag_state_type flags
);

   logic [otb_pkg::NUM_TIMERS-1:0] registered_ff, registered_in;
   logic [otb_pkg::NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [otb_pkg::NUM_TIMERS-1:0] pending_ff, pending_in;

   // Apply at most one slot update per cycle
   always_comb begin
      registered_in = registered_ff;
      armed_in      = armed_ff;
      pending_in    = pending_ff;
      unique case (cmd.op)
         otb_pkg::FLAG_SET: begin
            registered_in[cmd.slot] = 1'b1;
            armed_in[cmd.slot]      = 1'b1;
         end
         otb_pkg::FLAG_REARM: begin
            armed_in[cmd.slot]   = 1'b1;
            pending_in[cmd.slot] = 1'b0;
         end
         otb_pkg::FLAG_DISARM: begin
            armed_in[cmd.slot]   = 1'b0;
            pending_in[cmd.slot] = 1'b0;
         end
         otb_pkg::FLAG_FIRE: begin
            armed_in[cmd.slot]   = 1'b0;
            pending_in[cmd.slot] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         armed_ff      <= '0;
         pending_ff    <= '0;
      end else begin
         registered_ff <= registered_in;
         armed_ff      <= armed_in;
         pending_ff    <= pending_in;
      end
   end

   assign flags.registered = registered_ff;
   assign flags.armed      = armed_ff;
   assign flags.pending    = pending_ff;

endmodule

// ----- hw/rtl/otb_checker.sv -----
`include "assert_macros.svh"

module otb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_fired_valid,
   input logic [otb_pkg::ID_BITS-1:0]   rsp_fired_timer,
   input logic [otb_pkg::TASK_BITS-1:0] rsp_fired_task,
   input logic                          rsp_expired,
   input logic                          rsp_last
);

   logic                        seq_open_ff, seq_open_in;
   logic [otb_pkg::ID_BITS-1:0] prev_timer_ff, prev_timer_in;
   logic                        rsp_xfer;

   // Track a run of fired results belonging to one tick
   assign rsp_xfer      = rsp_valid && rsp_ready;
   assign seq_open_in   = rsp_xfer ? !rsp_last : seq_open_ff;
   assign prev_timer_in = (rsp_xfer && rsp_fired_valid) ? rsp_fired_timer : prev_timer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_open_ff <= 1'b0;
      end else begin
         seq_open_ff <= seq_open_in;
      end
      prev_timer_ff <= prev_timer_in;
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fired_valid) && $stable(rsp_fired_timer) && $stable(rsp_fired_task) && $stable(rsp_last), "response changed while stalled")
   `ASSERT_IMPLIES(a_query_alone, clock, reset, rsp_valid && rsp_expired, rsp_last && !rsp_fired_valid, "expired answer not a lone final result")
   `ASSERT_IMPLIES(a_mid_is_fire, clock, reset, rsp_valid && !rsp_last, rsp_fired_valid, "non-final result without a fired timer")
   `ASSERT_IMPLIES(a_fire_order, clock, reset, rsp_valid && rsp_fired_valid && seq_open_ff, rsp_fired_timer > prev_timer_ff, "fired timers out of index order")

endmodule

bind one_shot_timer_bank otb_checker u_otb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_fired_valid (rsp_ch.fired_valid),
   .rsp_fired_timer (rsp_ch.fired_timer),
   .rsp_fired_task  (rsp_ch.fired_task),
   .rsp_expired     (rsp_ch.expired),
   .rsp_last        (rsp_ch.last)
);
